>>> design/rsbs_pkg.sv
`default_nettype none

package rsbs_pkg;

  // Defaults for the top-level parameters.
  localparam int SPRITE_MAX_DEF      = 8;
  localparam int COORD_FRAC_BITS_DEF = 8;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // Blended ink must exceed this (about 0.002 at 16 fraction bits).
  localparam logic [16:0] INK_THRESHOLD = 17'd131;

  // Full brightness and full coverage.
  localparam logic [8:0] FULL_SCALE = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRITE_BITS    = 4'd0,
    CFG_SPRITE_WIDTH   = 4'd1,
    CFG_SPRITE_HEIGHT  = 4'd2,
    CFG_CENTER_X       = 4'd3,
    CFG_CENTER_Y       = 4'd4,
    CFG_COS_OVER_SCALE = 4'd5,
    CFG_SIN_OVER_SCALE = 4'd6,
    CFG_BRIGHTNESS     = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0]        sprite_bits;
    logic [3:0]         sprite_width;
    logic [3:0]         sprite_height;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] cos_over_scale;
    logic signed [15:0] sin_over_scale;
    logic [8:0]         brightness;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/rotated_sprite_bilinear_sampler_unit.sv
`default_nettype none

// Channel   Handshake              Payload
// --------  ---------------------  ----------------------------------------
// in        in_valid_i/in_stall_o  pixel_x_i, pixel_y_i
// out       out_valid_o/out_stall_i out_x_o, out_y_o, coverage_o
// cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One pixel per clock is taken while in_stall_o is low. When its ink is above
// threshold, its result is shown after the pixel passes through the queue and
// the five register stages of the back pipeline.
// Reset (rst_ni low, asynchronous) restores the configuration registers to their
// defaults and empties the queue and the pipeline; no clearing pass is needed.
// A stalled output freezes the five-stage back pipeline; the four-entry
// queue then fills, and in_stall_o rises only when that queue is full.

module rotated_sprite_bilinear_sampler_unit import rsbs_pkg::*; #(
  parameter int SPRITE_MAX      = SPRITE_MAX_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            pixel_x_i,
  input  wire logic [7:0]            pixel_y_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [7:0]                 out_x_o,
  output logic [7:0]                 out_y_o,
  output logic [8:0]                 coverage_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Offset from the rotation centre: the pixel centre can span F+8 bits and
  // the centre register 16 bits, plus a sign and a borrow.
  localparam int DW = ((COORD_FRAC_BITS + 8 > 16) ? (COORD_FRAC_BITS + 8) : 16) + 2;
  localparam int QW = 16 + 2 * DW;

  // Configuration registers. The port is always ready; the user must make writes only
  // while the block is idle (the block does not enforce it), so the datapath reads these directly.
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sprite_bits    <= '0;
      cfg_q.sprite_width   <= 4'd8;
      cfg_q.sprite_height  <= 4'd8;
      cfg_q.center_x       <= '0;
      cfg_q.center_y       <= '0;
      cfg_q.cos_over_scale <= 16'sd4096;
      cfg_q.sin_over_scale <= '0;
      cfg_q.brightness     <= FULL_SCALE;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPRITE_BITS:    cfg_q.sprite_bits    <= cfg_data_i;
        CFG_SPRITE_WIDTH:   cfg_q.sprite_width   <= cfg_data_i[3:0];
        CFG_SPRITE_HEIGHT:  cfg_q.sprite_height  <= cfg_data_i[3:0];
        CFG_CENTER_X:       cfg_q.center_x       <= $signed(cfg_data_i[15:0]);
        CFG_CENTER_Y:       cfg_q.center_y       <= $signed(cfg_data_i[15:0]);
        CFG_COS_OVER_SCALE: cfg_q.cos_over_scale <= $signed(cfg_data_i[15:0]);
        CFG_SIN_OVER_SCALE: cfg_q.sin_over_scale <= $signed(cfg_data_i[15:0]);
        CFG_BRIGHTNESS:     cfg_q.brightness     <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic          full, empty, push, pop;
  logic [QW-1:0] push_data, pop_data;

  // The front computes the offset from the rotation centre and drops pixels
  // that can never be drawn (empty sprite or zero brightness).
  rsbs_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .DW             (DW),
    .QW             (QW)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  rsbs_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (pop_data)
  );

  // The back rotates, samples the sprite, thresholds and scales; its final
  // stage is the output register.
  rsbs_back #(
    .SPRITE_MAX     (SPRITE_MAX),
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .DW             (DW),
    .QW             (QW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .coverage_o (coverage_o)
  );

endmodule

`default_nettype wire

>>> design/rsbs_queue.sv
`default_nettype none

module rsbs_queue import rsbs_pkg::*; #(
  parameter int WIDTH = 16,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count exceeds its depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

`default_nettype wire

>>> design/rsbs_front.sv
`default_nettype none

module rsbs_front import rsbs_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int DW              = 18,
  parameter int QW              = 16 + 2 * 18
) (
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    pixel_x_i,
  input  wire logic [7:0]    pixel_y_i,
  input  wire cfg_t          cfg_i,
  input  wire logic          full_i,
  output logic               push_o,
  output logic [QW-1:0]      push_data_o
);

  localparam int CTR_W = COORD_FRAC_BITS + 8;

  logic [CTR_W-1:0]    ctr_x, ctr_y;
  logic signed [DW-1:0] dx, dy;
  logic                 live;

  // Pixel centre: the coordinate shifted up plus one half.
  assign ctr_x = {pixel_x_i, 1'b1, {(COORD_FRAC_BITS - 1){1'b0}}};
  assign ctr_y = {pixel_y_i, 1'b1, {(COORD_FRAC_BITS - 1){1'b0}}};

  assign dx = $signed(DW'(ctr_x)) - {{(DW - 16){cfg_i.center_x[15]}}, cfg_i.center_x};
  assign dy = $signed(DW'(ctr_y)) - {{(DW - 16){cfg_i.center_y[15]}}, cfg_i.center_y};

  // An empty sprite or zero brightness never yields a pixel.
  assign live = (cfg_i.sprite_width != '0) && (cfg_i.sprite_height != '0) &&
                (cfg_i.brightness != '0);

  assign in_stall_o  = full_i;
  assign push_o      = in_valid_i && !full_i && live;
  assign push_data_o = {pixel_x_i, pixel_y_i, dx, dy};

endmodule

`default_nettype wire

>>> design/rsbs_back.sv
`default_nettype none

module rsbs_back import rsbs_pkg::*; #(
  parameter int SPRITE_MAX      = SPRITE_MAX_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
  parameter int DW              = 18,
  parameter int QW              = 16 + 2 * 18
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          empty_i,
  input  wire logic [QW-1:0] pop_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [7:0]         out_x_o,
  output logic [7:0]         out_y_o,
  output logic [8:0]         coverage_o
);

  localparam int PW      = DW + 16;
  localparam int UW      = PW + 2;
  localparam int UV_FRAC = COORD_FRAC_BITS + 12;
  localparam int IW      = UW - UV_FRAC;
  localparam int CW      = $clog2(SPRITE_MAX);

  logic en;

  // Configuration derived values.
  logic [3:0] w_sat, h_sat;
  logic [8:0] br_sat;

  assign w_sat  = (cfg_i.sprite_width > 4'(SPRITE_MAX)) ? 4'(SPRITE_MAX) : cfg_i.sprite_width;
  assign h_sat  = (cfg_i.sprite_height > 4'(SPRITE_MAX)) ? 4'(SPRITE_MAX) : cfg_i.sprite_height;
  assign br_sat = (cfg_i.brightness > FULL_SCALE) ? FULL_SCALE : cfg_i.brightness;

  assign en    = !out_valid_o || !out_stall_i;
  assign pop_o = en && !empty_i;

  // Stage 1: the four rotation products.
  logic signed [DW-1:0] dx_in, dy_in;
  logic                 v1_q;
  logic [7:0]           x1_q, y1_q;
  logic signed [PW-1:0] dxc_q, dys_q, dyc_q, dxs_q;

  assign dx_in = $signed(pop_data_i[2*DW-1:DW]);
  assign dy_in = $signed(pop_data_i[DW-1:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= pop_data_i[QW-1 -: 8];
      y1_q  <= pop_data_i[QW-9 -: 8];
      dxc_q <= PW'(dx_in) * PW'(cfg_i.cos_over_scale);
      dys_q <= PW'(dy_in) * PW'(cfg_i.sin_over_scale);
      dyc_q <= PW'(dy_in) * PW'(cfg_i.cos_over_scale);
      dxs_q <= PW'(dx_in) * PW'(cfg_i.sin_over_scale);
    end
  end

  // Stage 2: source coordinates with the sprite half-extent added.
  logic signed [UW-1:0] off_u, off_v;
  logic                 v2_q;
  logic [7:0]           x2_q, y2_q;
  logic signed [UW-1:0] u_q, v_q;

  assign off_u = $signed(UW'({w_sat - 4'd1, {(UV_FRAC - 1){1'b0}}}));
  assign off_v = $signed(UW'({h_sat - 4'd1, {(UV_FRAC - 1){1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q <= x1_q;
      y2_q <= y1_q;
      u_q  <= UW'(dxc_q) + UW'(dys_q) + off_u;
      v_q  <= UW'(dyc_q) - UW'(dxs_q) + off_v;
    end
  end

  // Stage 3: texel fetch and bilinear weights.
  logic signed [IW-1:0] col [2];
  logic signed [IW-1:0] row [2];
  logic [7:0]           fu, fv;
  logic [8:0]           wu [2];
  logic [8:0]           wv [2];
  logic                 col_ok [2];
  logic                 row_ok [2];
  logic [16:0]          wt [4];
  logic                 v3_q;
  logic [7:0]           x3_q, y3_q;
  logic [16:0]          wt_q [4];

  assign col[0] = u_q[UW-1:UV_FRAC];
  assign row[0] = v_q[UW-1:UV_FRAC];
  assign col[1] = col[0] + IW'(1);
  assign row[1] = row[0] + IW'(1);
  assign fu     = u_q[UV_FRAC-1 -: 8];
  assign fv     = v_q[UV_FRAC-1 -: 8];
  assign wu[0]  = FULL_SCALE - {1'b0, fu};
  assign wu[1]  = {1'b0, fu};
  assign wv[0]  = FULL_SCALE - {1'b0, fv};
  assign wv[1]  = {1'b0, fv};

  always_comb begin
    logic [5:0]  idx;
    logic [17:0] prod;
    for (int k = 0; k < 2; k++) begin
      col_ok[k] = !col[k][IW-1] && (col[k][IW-2:0] < (IW-1)'(w_sat));
      row_ok[k] = !row[k][IW-1] && (row[k][IW-2:0] < (IW-1)'(h_sat));
    end
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        idx  = 6'(row[r][CW-1:0]) * 6'(SPRITE_MAX) + 6'(col[c][CW-1:0]);
        prod = 18'(wu[c]) * 18'(wv[r]);
        wt[2*r+c] = (col_ok[c] && row_ok[r] && cfg_i.sprite_bits[idx]) ? prod[16:0] : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x3_q <= x2_q;
      y3_q <= y2_q;
      for (int k = 0; k < 4; k++) begin
        wt_q[k] <= wt[k];
      end
    end
  end

  // Stage 4: total ink and the threshold.
  logic [18:0] ink_sum;
  logic        v4_q;
  logic [7:0]  x4_q, y4_q;
  logic [16:0] ink_q;

  assign ink_sum = 19'(wt_q[0]) + 19'(wt_q[1]) + 19'(wt_q[2]) + 19'(wt_q[3]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x4_q  <= x3_q;
      y4_q  <= y3_q;
      ink_q <= ink_sum[16:0];
    end
  end

  // Stage 5: scale by brightness with rounding into the output register.
  logic [25:0] scaled;
  logic [9:0]  cov_raw;
  logic [8:0]  cov;
  logic        out_valid_q;
  logic [7:0]  out_x_q, out_y_q;
  logic [8:0]  coverage_q;

  assign scaled  = 26'(ink_q) * 26'(br_sat) + 26'(32768);
  assign cov_raw = scaled[25:16];
  assign cov     = (cov_raw > 10'(FULL_SCALE)) ? FULL_SCALE : cov_raw[8:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q    <= x4_q;
      out_y_q    <= y4_q;
      coverage_q <= cov;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= !empty_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q && (ink_sum[16:0] > INK_THRESHOLD);
      out_valid_q <= v4_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign coverage_o  = coverage_q;

  a_ink_above_threshold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (ink_q > INK_THRESHOLD))
    else $error("pixel below the ink threshold reached the scaling stage");

  a_coverage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (coverage_q <= FULL_SCALE))
    else $error("coverage above full scale");

  a_pop_only_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (en && !empty_i))
    else $error("queue popped while the pipeline holds");

endmodule

`default_nettype wire
